// ----- hw/rtl/llist_pkg.sv -----
// shared types, constants and command structures for the linked list manager
package llist_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned TEXT_BITS_DEF = 64;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NODE_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned CHUNK    = 16;
  localparam int unsigned CHUNK_BW = $clog2(CHUNK);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_HEAD  = 3'd0,
    MODE_ADD_AFTER = 3'd1,
    MODE_ADD_TAIL  = 3'd2,
    MODE_DEL_HEAD  = 3'd3,
    MODE_DEL_AFTER = 3'd4,
    MODE_DEL_TAIL  = 3'd5,
    MODE_CLEAR     = 3'd6,
    MODE_DUMP      = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RA_HEAD = 2'd0,
    RA_SLOT = 2'd1,
    RA_LINK = 2'd2
  } rd_addr_t;

  typedef enum logic [1:0] {
    WA_FS   = 2'd0,
    WA_CUR  = 2'd1,
    WA_PREV = 2'd2
  } wr_addr_t;

  typedef enum logic [1:0] {
    WD_HEAD = 2'd0,
    WD_NIL  = 2'd1,
    WD_LINK = 2'd2,
    WD_FS   = 2'd3
  } wr_data_t;

  typedef enum logic [1:0] {
    HD_KEEP = 2'd0,
    HD_FS   = 2'd1,
    HD_LINK = 2'd2,
    HD_NIL  = 2'd3
  } head_src_t;

  typedef enum logic [1:0] {
    NS_ZERO = 2'd0,
    NS_FS   = 2'd1,
    NS_CUR  = 2'd2
  } node_src_t;

  typedef struct packed {
    logic      load;
    logic      rd;
    rd_addr_t  rd_addr;
    logic      wr;
    wr_addr_t  wr_addr;
    wr_data_t  wr_data;
    head_src_t head_src;
    logic      search;
    logic      take;
    logic      free;
    logic      clear;
    logic      out_load;
    status_t   out_status;
    node_src_t out_node;
    logic      out_data;
    logic      out_final;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  slot_ok;
    logic  head_nil;
    logic  full;
    logic  link_nil;
    logic  hit;
    logic  out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/llist_ctrl.sv -----
// controller state machine sequencing each list operation
module llist_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  llist_pkg::dp_stat_t st,
  output llist_pkg::dp_cmd_t  cmd
);
  import llist_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_WALK   = 11'b000_0000_0100,
    S_SEARCH = 11'b000_0000_1000,
    S_TAKE   = 11'b000_0001_0000,
    S_LINK   = 11'b000_0010_0000,
    S_POP    = 11'b000_0100_0000,
    S_STEP   = 11'b000_1000_0000,
    S_UNLINK = 11'b001_0000_0000,
    S_DUMP   = 11'b010_0000_0000,
    S_RESP   = 11'b100_0000_0000
  } state_t;

  state_t  state, state_next;
  status_t resp_status, resp_status_next;
  logic    resp_fs, resp_fs_next;
  logic    stepped, stepped_next;
  logic    tail_ins, tail_ins_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_status <= ST_OK;
      resp_fs     <= 1'b0;
      stepped     <= 1'b0;
      tail_ins    <= 1'b0;
    end else begin
      state       <= state_next;
      resp_status <= resp_status_next;
      resp_fs     <= resp_fs_next;
      stepped     <= stepped_next;
      tail_ins    <= tail_ins_next;
    end
  end

  always_comb begin
    cmd              = '0;
    item_stall       = 1'b1;
    state_next       = state;
    resp_status_next = resp_status;
    resp_fs_next     = resp_fs;
    stepped_next     = stepped;
    tail_ins_next    = tail_ins;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        resp_fs_next     = 1'b0;
        stepped_next     = 1'b0;
        tail_ins_next    = 1'b0;
        resp_status_next = ST_OK;
        state_next       = S_RESP;
        unique case (st.mode)
          MODE_ADD_HEAD: begin
            if (st.full) resp_status_next = ST_FULL;
            else state_next = S_SEARCH;
          end
          MODE_ADD_AFTER: begin
            if (!st.slot_ok) begin
              resp_status_next = ST_BAD_SLOT;
            end else if (st.full) begin
              resp_status_next = ST_FULL;
            end else begin
              cmd.rd      = 1'b1;
              cmd.rd_addr = RA_SLOT;
              state_next  = S_SEARCH;
            end
          end
          MODE_ADD_TAIL: begin
            if (st.full) begin
              resp_status_next = ST_FULL;
            end else if (st.head_nil) begin
              state_next = S_SEARCH;
            end else begin
              cmd.rd        = 1'b1;
              cmd.rd_addr   = RA_HEAD;
              tail_ins_next = 1'b1;
              state_next    = S_WALK;
            end
          end
          MODE_DEL_HEAD: begin
            if (st.head_nil) begin
              resp_status_next = ST_EMPTY;
            end else begin
              cmd.rd      = 1'b1;
              cmd.rd_addr = RA_HEAD;
              state_next  = S_POP;
            end
          end
          MODE_DEL_AFTER: begin
            if (!st.slot_ok) begin
              resp_status_next = ST_BAD_SLOT;
            end else begin
              cmd.rd      = 1'b1;
              cmd.rd_addr = RA_SLOT;
              state_next  = S_STEP;
            end
          end
          MODE_DEL_TAIL: begin
            if (st.head_nil) begin
              resp_status_next = ST_EMPTY;
            end else begin
              cmd.rd      = 1'b1;
              cmd.rd_addr = RA_HEAD;
              state_next  = S_WALK;
            end
          end
          MODE_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.head_src = HD_NIL;
          end
          default: begin
            if (st.head_nil) begin
              resp_status_next = ST_EMPTY;
            end else begin
              cmd.rd      = 1'b1;
              cmd.rd_addr = RA_HEAD;
              state_next  = S_DUMP;
            end
          end
        endcase
      end
      S_WALK: begin
        if (!st.link_nil) begin
          cmd.rd       = 1'b1;
          cmd.rd_addr  = RA_LINK;
          stepped_next = 1'b1;
        end else if (tail_ins) begin
          state_next = S_SEARCH;
        end else begin
          // tail removal: unlink from predecessor, or empty the list
          if (stepped) begin
            cmd.wr      = 1'b1;
            cmd.wr_addr = WA_PREV;
            cmd.wr_data = WD_NIL;
          end else begin
            cmd.head_src = HD_NIL;
          end
          cmd.free   = 1'b1;
          state_next = S_RESP;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (st.hit) state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.take     = 1'b1;
        cmd.wr       = 1'b1;
        cmd.wr_addr  = WA_FS;
        resp_fs_next = 1'b1;
        if (st.mode == MODE_ADD_AFTER) begin
          cmd.wr_data = WD_LINK;
          state_next  = S_LINK;
        end else if (tail_ins) begin
          cmd.wr_data = WD_NIL;
          state_next  = S_LINK;
        end else begin
          cmd.wr_data  = WD_HEAD;
          cmd.head_src = HD_FS;
          state_next   = S_RESP;
        end
      end
      S_LINK: begin
        cmd.wr      = 1'b1;
        cmd.wr_addr = WA_CUR;
        cmd.wr_data = WD_FS;
        state_next  = S_RESP;
      end
      S_POP: begin
        cmd.head_src = HD_LINK;
        cmd.free     = 1'b1;
        state_next   = S_RESP;
      end
      S_STEP: begin
        if (st.link_nil) begin
          resp_status_next = ST_EMPTY;
          state_next       = S_RESP;
        end else begin
          cmd.rd      = 1'b1;
          cmd.rd_addr = RA_LINK;
          state_next  = S_UNLINK;
        end
      end
      S_UNLINK: begin
        cmd.wr      = 1'b1;
        cmd.wr_addr = WA_PREV;
        cmd.wr_data = WD_LINK;
        cmd.free    = 1'b1;
        state_next  = S_RESP;
      end
      S_DUMP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_node   = NS_CUR;
          cmd.out_data   = 1'b1;
          cmd.out_final  = st.link_nil;
          if (st.link_nil) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd      = 1'b1;
            cmd.rd_addr = RA_LINK;
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_status;
          cmd.out_node   = resp_fs ? NS_FS : NS_ZERO;
          cmd.out_final  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/llist_dp.sv -----
// datapath: node stores, link store, slot map, free slot search and result register
module llist_dp #(
  parameter int unsigned DEPTH     = llist_pkg::DEPTH_DEF,
  parameter int unsigned TEXT_BITS = llist_pkg::TEXT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  llist_pkg::dp_cmd_t                  cmd,
  output llist_pkg::dp_stat_t                 st,
  input  logic [llist_pkg::MODE_W-1:0]        mode,
  input  logic [llist_pkg::SLOT_W-1:0]        slot,
  input  logic [llist_pkg::WORD_W-1:0]        word_id,
  input  logic [llist_pkg::WORD_W-1:0]        word_name,
  input  logic [llist_pkg::WORD_W-1:0]        word_grade,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [llist_pkg::STATUS_W-1:0]      status,
  output logic [llist_pkg::NODE_W-1:0]        node,
  output logic [llist_pkg::COUNT_W-1:0]       count,
  output logic [llist_pkg::WORD_W-1:0]        out_id,
  output logic [llist_pkg::WORD_W-1:0]        out_name,
  output logic [llist_pkg::WORD_W-1:0]        out_grade,
  output logic                                final_res
);
  import llist_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned LW   = $clog2(DEPTH + 1);
  localparam int unsigned NCH  = (DEPTH + CHUNK - 1) / CHUNK;
  localparam int unsigned CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PADW = (2 ** CHW) * CHUNK;
  localparam int unsigned TW   = 3 * TEXT_BITS;
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  mode_t                mode_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [TEXT_BITS-1:0] wid_r, wname_r, wgrade_r;

  logic [LW-1:0]        head;
  logic [LW-1:0]        elem_count;
  logic [DEPTH-1:0]     used;
  logic [PADW-1:0]      used_pad;

  logic [LW-1:0]        link_mem [DEPTH];
  logic [TW-1:0]        text_mem [DEPTH];
  logic [LW-1:0]        link_rd;
  logic [TW-1:0]        text_rd;

  logic [AW-1:0]        cur, prev, fs;
  logic [CHW-1:0]       chunk;

  logic [AW-1:0]        slot_idx, rd_addr, wr_addr;
  logic [LW-1:0]        wr_data;
  logic [CHUNK-1:0]     free_bits;
  logic [CHUNK_BW-1:0]  pick;

  assign slot_idx = AW'(slot_r);

  always_comb begin
    used_pad            = '1;
    used_pad[DEPTH-1:0] = used;
  end

  assign free_bits = ~used_pad[chunk * CHUNK +: CHUNK];

  always_comb begin
    pick = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (free_bits[i]) pick = CHUNK_BW'(i);
    end
  end

  always_comb begin
    st.mode     = mode_r;
    st.slot_ok  = (32'(slot_r) < DEPTH) && used_pad[slot_idx];
    st.head_nil = (head == NIL);
    st.full     = (elem_count == NIL);
    st.link_nil = (link_rd == NIL);
    st.hit      = |free_bits;
    st.out_free = !res_valid || !res_stall;
  end

  always_comb begin
    case (cmd.rd_addr)
      RA_HEAD: rd_addr = head[AW-1:0];
      RA_SLOT: rd_addr = slot_idx;
      default: rd_addr = link_rd[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_addr)
      WA_FS:   wr_addr = fs;
      WA_CUR:  wr_addr = cur;
      default: wr_addr = prev;
    endcase
  end

  always_comb begin
    case (cmd.wr_data)
      WD_HEAD: wr_data = head;
      WD_NIL:  wr_data = NIL;
      WD_LINK: wr_data = link_rd;
      default: wr_data = LW'(fs);
    endcase
  end

  // link and text stores
  always_ff @(posedge clk) begin
    if (cmd.wr) link_mem[wr_addr] <= wr_data;
    if (cmd.take) text_mem[fs] <= {wgrade_r, wname_r, wid_r};
    if (cmd.rd) begin
      link_rd <= link_mem[rd_addr];
      text_rd <= text_mem[rd_addr];
    end
  end

  // operands and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= mode_t'(mode);
      slot_r   <= slot;
      wid_r    <= word_id[TEXT_BITS-1:0];
      wname_r  <= word_name[TEXT_BITS-1:0];
      wgrade_r <= word_grade[TEXT_BITS-1:0];
    end
    if (cmd.rd) begin
      cur  <= rd_addr;
      prev <= cur;
    end
    if (cmd.search && st.hit) fs <= AW'({chunk, pick});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= NIL;
      elem_count <= '0;
      used       <= '0;
      chunk      <= '0;
    end else begin
      case (cmd.head_src)
        HD_FS:   head <= LW'(fs);
        HD_LINK: head <= link_rd;
        HD_NIL:  head <= NIL;
        default: head <= head;
      endcase
      if (cmd.clear) begin
        used       <= '0;
        elem_count <= '0;
      end else if (cmd.take) begin
        used[fs]   <= 1'b1;
        elem_count <= elem_count + LW'(1);
      end else if (cmd.free) begin
        used[cur]  <= 1'b0;
        elem_count <= elem_count - LW'(1);
      end
      if (cmd.search) chunk <= st.hit ? '0 : chunk + CHW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= cmd.out_status;
      count     <= COUNT_W'(elem_count);
      final_res <= cmd.out_final;
      case (cmd.out_node)
        NS_FS:   node <= NODE_W'(fs);
        NS_CUR:  node <= NODE_W'(cur);
        default: node <= '0;
      endcase
      if (cmd.out_data) begin
        out_id    <= WORD_W'(text_rd[TEXT_BITS-1:0]);
        out_name  <= WORD_W'(text_rd[2*TEXT_BITS-1:TEXT_BITS]);
        out_grade <= WORD_W'(text_rd[3*TEXT_BITS-1:2*TEXT_BITS]);
      end else begin
        out_id    <= '0;
        out_name  <= '0;
        out_grade <= '0;
      end
    end
  end

endmodule

// ----- hw/rtl/linked_list_manager.sv -----
// top level of the bounded singly linked list manager
// states, beat to result: decode, response for clear and full, bad slot or empty-list replies;
//   delete head adds pop, delete after adds step, then unlink if a successor exists; inserts add
//   search over 16-slot groups and take, then link for insert after and non-empty tail insert;
//   the latter and delete tail walk first, one link read per cycle; dump: one result per node
// next beat taken the cycle after the last result loads; reset empties the list, frees all slots
module linked_list_manager #(
  parameter int unsigned DEPTH     = llist_pkg::DEPTH_DEF,
  parameter int unsigned TEXT_BITS = llist_pkg::TEXT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [llist_pkg::MODE_W-1:0]   mode,
  input  logic [llist_pkg::SLOT_W-1:0]   slot,
  input  logic [llist_pkg::WORD_W-1:0]   word_id,
  input  logic [llist_pkg::WORD_W-1:0]   word_name,
  input  logic [llist_pkg::WORD_W-1:0]   word_grade,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [llist_pkg::STATUS_W-1:0] status,
  output logic [llist_pkg::NODE_W-1:0]   node,
  output logic [llist_pkg::COUNT_W-1:0]  count,
  output logic [llist_pkg::WORD_W-1:0]   out_id,
  output logic [llist_pkg::WORD_W-1:0]   out_name,
  output logic [llist_pkg::WORD_W-1:0]   out_grade,
  output logic                           final_res
);
  import llist_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  llist_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  llist_dp #(
    .DEPTH     (DEPTH),
    .TEXT_BITS (TEXT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .mode       (mode),
    .slot       (slot),
    .word_id    (word_id),
    .word_name  (word_name),
    .word_grade (word_grade),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .node       (node),
    .count      (count),
    .out_id     (out_id),
    .out_name   (out_name),
    .out_grade  (out_grade),
    .final_res  (final_res)
  );

endmodule

// ----- tb/tb_linked_list_manager.sv -----
// testbench for the linked list manager: predicted list operations checked beat by beat
module tb_linked_list_manager;
  timeunit 1ns;
  timeprecision 1ps;
  import llist_pkg::*;

  localparam int NSLOT       = 16;
  localparam int NIL         = NSLOT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN       = 10;

  typedef struct {
    status_t             status;
    logic [NODE_W-1:0]   node;
    logic [COUNT_W-1:0]  count;
    logic [WORD_W-1:0]   id;
    logic [WORD_W-1:0]   name;
    logic [WORD_W-1:0]   grade;
    logic                fin;
  } list_beat_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [MODE_W-1:0]   mode       = '0;
  logic [SLOT_W-1:0]   slot       = '0;
  logic [WORD_W-1:0]   word_id    = '0;
  logic [WORD_W-1:0]   word_name  = '0;
  logic [WORD_W-1:0]   word_grade = '0;
  logic                res_valid;
  logic                res_stall  = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   node;
  logic [COUNT_W-1:0]  count;
  logic [WORD_W-1:0]   out_id;
  logic [WORD_W-1:0]   out_name;
  logic [WORD_W-1:0]   out_grade;
  logic                final_res;

  // list image kept alongside the block
  int                lst_head = NIL;
  int                lst_next [NSLOT];
  logic [WORD_W-1:0] rec_id [NSLOT];
  logic [WORD_W-1:0] rec_name [NSLOT];
  logic [WORD_W-1:0] rec_grade [NSLOT];
  bit                slot_taken [NSLOT];
  int                n_elem = 0;

  list_beat_t expected_beats [$];
  list_beat_t want;
  bit         no_idle      = 1'b0;
  int         mismatches   = 0;
  int         ops_sent     = 0;
  int         beats_seen   = 0;
  int         full_hits    = 0;
  int         longest_dump = 0;
  int         cycles       = 0;

  mode_t add_modes [3] = '{MODE_ADD_HEAD, MODE_ADD_AFTER, MODE_ADD_TAIL};
  mode_t del_modes [3] = '{MODE_DEL_HEAD, MODE_DEL_AFTER, MODE_DEL_TAIL};

  linked_list_manager dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .slot       (slot),
    .word_id    (word_id),
    .word_name  (word_name),
    .word_grade (word_grade),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .node       (node),
    .count      (count),
    .out_id     (out_id),
    .out_name   (out_name),
    .out_grade  (out_grade),
    .final_res  (final_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_beat(status_t st, int nd, int src, bit fin);
    list_beat_t b;
    b.status = st;
    b.node   = NODE_W'(nd);
    b.count  = COUNT_W'(n_elem);
    b.id     = '0;
    b.name   = '0;
    b.grade  = '0;
    if (src < NSLOT) begin
      b.id    = rec_id[src];
      b.name  = rec_name[src];
      b.grade = rec_grade[src];
    end
    b.fin = fin;
    if (st == ST_FULL) full_hits++;
    expected_beats.push_back(b);
  endfunction

  // lowest free slot takes the new record
  function automatic int alloc_slot(logic [WORD_W-1:0] wi, logic [WORD_W-1:0] wn,
                                    logic [WORD_W-1:0] wg);
    for (int i = 0; i < NSLOT; i++) begin
      if (!slot_taken[i]) begin
        slot_taken[i] = 1'b1;
        rec_id[i]     = wi;
        rec_name[i]   = wn;
        rec_grade[i]  = wg;
        lst_next[i]   = NIL;
        n_elem++;
        return i;
      end
    end
    return NIL;
  endfunction

  function automatic void drop_slot(int s);
    if (s < NSLOT) begin
      slot_taken[s] = 1'b0;
      if (n_elem > 0) n_elem--;
    end
  endfunction

  function automatic void predict_op(mode_t m, logic [SLOT_W-1:0] sl, logic [WORD_W-1:0] wi,
                                     logic [WORD_W-1:0] wn, logic [WORD_W-1:0] wg);
    int s;
    int t;
    int p;
    int k;
    bit sl_ok;
    sl_ok = slot_taken[sl];
    case (m)
      MODE_ADD_HEAD, MODE_ADD_TAIL: begin
        t = NIL;
        if (m == MODE_ADD_TAIL && lst_head < NSLOT) begin
          t = lst_head;
          for (int n = 0; n < NSLOT && lst_next[t] < NSLOT; n++) t = lst_next[t];
        end
        s = alloc_slot(wi, wn, wg);
        if (s == NIL) begin
          push_beat(ST_FULL, 0, NIL, 1'b1);
        end else begin
          if (t != NIL) begin
            lst_next[t] = s;
          end else begin
            lst_next[s] = lst_head;
            lst_head    = s;
          end
          push_beat(ST_OK, s, NIL, 1'b1);
        end
      end
      MODE_ADD_AFTER: begin
        if (!sl_ok) begin
          push_beat(ST_BAD_SLOT, 0, NIL, 1'b1);
        end else begin
          s = alloc_slot(wi, wn, wg);
          if (s == NIL) begin
            push_beat(ST_FULL, 0, NIL, 1'b1);
          end else begin
            lst_next[s]  = lst_next[sl];
            lst_next[sl] = s;
            push_beat(ST_OK, s, NIL, 1'b1);
          end
        end
      end
      MODE_DEL_HEAD: begin
        if (lst_head >= NSLOT) begin
          push_beat(ST_EMPTY, 0, NIL, 1'b1);
        end else begin
          s        = lst_head;
          lst_head = lst_next[s];
          drop_slot(s);
          push_beat(ST_OK, 0, NIL, 1'b1);
        end
      end
      MODE_DEL_AFTER: begin
        if (!sl_ok) begin
          push_beat(ST_BAD_SLOT, 0, NIL, 1'b1);
        end else if (lst_next[sl] >= NSLOT) begin
          push_beat(ST_EMPTY, 0, NIL, 1'b1);
        end else begin
          s            = lst_next[sl];
          lst_next[sl] = lst_next[s];
          drop_slot(s);
          push_beat(ST_OK, 0, NIL, 1'b1);
        end
      end
      MODE_DEL_TAIL: begin
        if (lst_head >= NSLOT) begin
          push_beat(ST_EMPTY, 0, NIL, 1'b1);
        end else begin
          s = lst_head;
          if (lst_next[s] >= NSLOT) begin
            lst_head = NIL;
          end else begin
            p = s;
            s = lst_next[s];
            for (int n = 0; n < NSLOT && lst_next[s] < NSLOT; n++) begin
              p = s;
              s = lst_next[s];
            end
            lst_next[p] = NIL;
          end
          drop_slot(s);
          push_beat(ST_OK, 0, NIL, 1'b1);
        end
      end
      MODE_CLEAR: begin
        lst_head = NIL;
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        n_elem = 0;
        push_beat(ST_OK, 0, NIL, 1'b1);
      end
      default: begin
        if (lst_head >= NSLOT) begin
          push_beat(ST_EMPTY, 0, NIL, 1'b1);
        end else begin
          k = 0;
          p = lst_head;
          while (p < NSLOT && k < NSLOT) begin
            t = lst_next[p];
            push_beat(ST_OK, p, p, (t >= NSLOT || k + 1 >= NSLOT));
            k++;
            p = t;
          end
          if (k > longest_dump) longest_dump = k;
        end
      end
    endcase
  endfunction

  task automatic send_op(mode_t m, logic [SLOT_W-1:0] sl, logic [WORD_W-1:0] wi,
                         logic [WORD_W-1:0] wn, logic [WORD_W-1:0] wg);
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    mode       <= m;
    slot       <= sl;
    word_id    <= wi;
    word_name  <= wn;
    word_grade <= wg;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_op(m, sl, wi, wn, wg);
    ops_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(bit any_ok);
    int on_list [$];
    foreach (slot_taken[i]) if (slot_taken[i]) on_list.push_back(i);
    if (on_list.size() != 0 && (!any_ok || $urandom_range(0, 99) < 80))
      return SLOT_W'(on_list[$urandom_range(0, on_list.size() - 1)]);
    return SLOT_W'($urandom_range(0, NSLOT - 1));
  endfunction

  task automatic test_empty_list();
    send_op(MODE_DEL_HEAD, 0, '0, '0, '0);
    send_op(MODE_DEL_TAIL, 0, '0, '0, '0);
    send_op(MODE_DEL_AFTER, 0, '0, '0, '0);
    send_op(MODE_ADD_AFTER, 15, '1, '1, '1);
    send_op(MODE_DUMP, 0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_basic_ops();
    send_op(MODE_ADD_HEAD, 0, '1, '1, '1);
    send_op(MODE_ADD_TAIL, 0, '0, '0, '0);
    send_op(MODE_ADD_AFTER, 0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h0123_4567_89AB_CDEF);
    send_op(MODE_ADD_TAIL, 0, rand_word(), rand_word(), rand_word());
    send_op(MODE_DUMP, 0, '0, '0, '0);
    // last node has no successor
    send_op(MODE_DEL_AFTER, 3, '0, '0, '0);
    send_op(MODE_DEL_AFTER, 0, '0, '0, '0);
    send_op(MODE_DEL_TAIL, 0, '0, '0, '0);
    send_op(MODE_DEL_HEAD, 0, '0, '0, '0);
    send_op(MODE_DUMP, 0, '0, '0, '0);
    send_op(MODE_ADD_AFTER, 7, '0, '0, '0);
    send_op(MODE_DEL_AFTER, 9, '0, '0, '0);
    send_op(MODE_CLEAR, 0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_store();
    while (n_elem < NSLOT)
      send_op(add_modes[$urandom_range(0, 2)], pick_slot(1'b0), rand_word(), rand_word(),
              rand_word());
    send_op(MODE_ADD_HEAD, 0, rand_word(), rand_word(), rand_word());
    send_op(MODE_ADD_TAIL, 0, rand_word(), rand_word(), rand_word());
    send_op(MODE_ADD_AFTER, pick_slot(1'b0), rand_word(), rand_word(), rand_word());
    send_op(MODE_DUMP, 0, '0, '0, '0);
    send_op(MODE_DEL_TAIL, 0, '0, '0, '0);
    send_op(MODE_DEL_AFTER, pick_slot(1'b0), '0, '0, '0);
    send_op(MODE_DEL_HEAD, 0, '0, '0, '0);
    send_op(MODE_DUMP, 0, '0, '0, '0);
    send_op(MODE_CLEAR, 0, '0, '0, '0);
    send_op(MODE_DUMP, 0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_ops();
    mode_t m;
    int    r;
    bit    grow;
    for (int i = 0; i < 190; i++) begin
      no_idle = (i >= 70 && i < 120);
      grow    = ((i / 40) % 2 == 0);
      r       = $urandom_range(0, 99);
      if (r < 5)                    m = mode_t'($urandom_range(0, 7));
      else if (r < (grow ? 60 : 28)) m = add_modes[$urandom_range(0, 2)];
      else if (r < 88)              m = del_modes[$urandom_range(0, 2)];
      else if (r < 98)              m = MODE_DUMP;
      else                          m = MODE_CLEAR;
      send_op(m, pick_slot(1'b1), rand_word(), rand_word(), rand_word());
      if (i == 100) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  always @(negedge clk) begin
    res_stall <= !no_idle && ($urandom_range(0, 99) < 24);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN)
          $display("unexpected result beat: status %0d node %0d count %0d final %0d",
                   status, node, count, final_res);
      end else begin
        want = expected_beats.pop_front();
        if (status !== want.status || node !== want.node || count !== want.count ||
            out_id !== want.id || out_name !== want.name || out_grade !== want.grade ||
            final_res !== want.fin) begin
          mismatches++;
          if (mismatches <= SHOWN) begin
            $display("beat %0d expected: st %0d node %0d cnt %0d id %h name %h grade %h fin %0d",
                     beats_seen, want.status, want.node, want.count, want.id, want.name,
                     want.grade, want.fin);
            $display("beat %0d actual:   st %0d node %0d cnt %0d id %h name %h grade %h fin %0d",
                     beats_seen, status, node, count, out_id, out_name, out_grade, final_res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d result beats outstanding", expected_beats.size());
      $display("tb_linked_list_manager failed");
      $finish;
    end
  end

  initial begin
    foreach (lst_next[i]) begin
      lst_next[i]   = 0;
      rec_id[i]     = '0;
      rec_name[i]   = '0;
      rec_grade[i]  = '0;
      slot_taken[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_basic_ops();
    test_full_store();
    test_random_ops();
    repeat (60) @(posedge clk);
    if (expected_beats.size() != 0) begin
      mismatches += expected_beats.size();
      $display("%0d expected result beats never arrived", expected_beats.size());
    end
    $display("%0d operations over all eight modes, %0d result beats compared",
             ops_sent, beats_seen);
    $display("store-full replies %0d, longest dump %0d nodes, mismatches %0d",
             full_hits, longest_dump, mismatches);
    if (mismatches == 0) begin
      $display("tb_linked_list_manager passed");
    end else begin
      $display("tb_linked_list_manager failed");
    end
    $finish;
  end

endmodule

// ----- linked_list_manager.f -----
hw/rtl/llist_pkg.sv
hw/rtl/llist_ctrl.sv
hw/rtl/llist_dp.sv
hw/rtl/linked_list_manager.sv
tb/tb_linked_list_manager.sv
